### rtl/flbm_pkg.sv
// flbm_pkg: shared constants, op, request and status codes and the line
// control struct of the fixed latency burst memory
// no dependencies
`default_nettype none

package flbm_pkg;

    // default configuration
    localparam int DEF_WORD_BYTES  = 8;
    localparam int DEF_LATENCY     = 4;
    localparam int DEF_BURST_WORDS = 4;
    localparam int DEF_MEM_BYTES   = 65536;
    localparam int DEF_TAG_BITS    = 8;

    // fixed field widths of the stream payload
    localparam int ADDR_W      = 16;
    localparam int DATA_PORT_W = 64;
    localparam int TAG_PORT_W  = 8;
    localparam int BE_PORT_W   = 8;

    typedef logic [1:0] op_t;
    typedef logic [1:0] req_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_REQUEST = 2'd0;
    localparam op_t OP_TICK    = 2'd1;
    localparam op_t OP_DEQUEUE = 2'd2;

    localparam req_t REQ_BURST  = 2'd0;
    localparam req_t REQ_STORE  = 2'd1;
    localparam req_t REQ_SINGLE = 2'd2;
    localparam req_t REQ_NONE   = 2'd3;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BUSY      = 3'd1;
    localparam status_t ST_EMPTY     = 3'd2;
    localparam status_t ST_UNALIGNED = 3'd3;
    localparam status_t ST_RANGE     = 3'd4;

    // one command to the response line per cycle
    typedef struct packed {
        logic shift;
        logic dequeue;
        logic put;
    } line_ctrl_t;

endpackage

`default_nettype wire

### rtl/flbm_mem.sv
// flbm_mem: word memory with a byte-masked write port and one registered
// read port; depends on flbm_pkg only through the parent's parameters
`default_nettype none

module flbm_mem #(
    parameter int WORD_BYTES = 8,
    parameter int DEPTH      = 8192,
    localparam int DATA_W    = 8 * WORD_BYTES,
    localparam int IDX_W     = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic [WORD_BYTES-1:0] we,
    input  wire logic [IDX_W-1:0]      waddr,
    input  wire logic [DATA_W-1:0]     wdata,
    input  wire logic                  re,
    input  wire logic [IDX_W-1:0]      raddr,
    output logic      [DATA_W-1:0]     rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            if (we[b])
            begin
                mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/flbm_line.sv
// flbm_line: the response line, LATENCY slots that shift toward the head
// depends on flbm_pkg for the line control struct and the request type
`default_nettype none

module flbm_line #(
    parameter int LATENCY     = 4,
    parameter int BURST_WORDS = 4,
    parameter int TAG_W       = 8,
    parameter int DATA_W      = 64,
    localparam int SLOT_W     = (LATENCY > 1) ? $clog2(LATENCY) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire flbm_pkg::line_ctrl_t ctrl,
    input  wire logic [SLOT_W-1:0]    put_slot,
    input  wire flbm_pkg::req_t       put_type,
    input  wire logic [TAG_W-1:0]     put_tag,
    input  wire logic [DATA_W-1:0]    put_data,
    output logic                      head_valid,
    output flbm_pkg::req_t            head_type,
    output logic      [TAG_W-1:0]     head_tag,
    output logic      [DATA_W-1:0]    head_data,
    output logic                      burst_room
);

    import flbm_pkg::*;

    localparam int BURST_N    = (BURST_WORDS > LATENCY) ? LATENCY : BURST_WORDS;
    localparam int FIRST_SLOT = LATENCY - BURST_N;

    logic              valid_reg [LATENCY];
    req_t              type_reg  [LATENCY];
    logic [TAG_W-1:0]  tag_reg   [LATENCY];
    logic [DATA_W-1:0] data_reg  [LATENCY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (ctrl.shift)
            begin
                for (int i = 0; i < LATENCY - 1; i++)
                begin
                    valid_reg[i] <= valid_reg[i+1];
                end
                valid_reg[LATENCY-1] <= 1'b0;
            end
            if (ctrl.dequeue)
            begin
                valid_reg[0] <= 1'b0;
            end
            if (ctrl.put)
            begin
                valid_reg[put_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int i = 0; i < LATENCY - 1; i++)
            begin
                type_reg[i] <= type_reg[i+1];
                tag_reg[i]  <= tag_reg[i+1];
                data_reg[i] <= data_reg[i+1];
            end
        end
        if (ctrl.put)
        begin
            type_reg[put_slot] <= put_type;
            tag_reg[put_slot]  <= put_tag;
            data_reg[put_slot] <= put_data;
        end
    end

    // room for a burst once the line has shifted: old slots above the
    // first burst slot must be empty, the tail is always free after a shift
    always_comb
    begin
        burst_room = 1'b1;
        for (int i = FIRST_SLOT; i < LATENCY - 1; i++)
        begin
            if (valid_reg[i+1])
            begin
                burst_room = 1'b0;
            end
        end
    end

    assign head_valid = valid_reg[0];
    assign head_type  = type_reg[0];
    assign head_tag   = tag_reg[0];
    assign head_data  = data_reg[0];

endmodule

`default_nettype wire

### rtl/fixed_latency_burst_memory.sv
// fixed_latency_burst_memory: top level with the request register, the
// sequencer and the result register; uses flbm_pkg, flbm_mem and flbm_line
//
// Each request, tick or dequeue on the slave stream returns exactly one
// result on the master stream showing the head of the response line, the
// request register state and a status code. The block works on one request
// at a time: a request, dequeue or plain tick steps through accept, execute
// and result (S_IDLE, S_EXEC, S_FIN) before the next accept; a tick that
// serves a load adds one fill step (S_FILL) per word read, one for a single
// load and min(BURST_WORDS, LATENCY) for a burst. The extra steps come from
// the single read port of the word memory, which returns one registered
// word per cycle. Stores write the memory in the execute cycle. The word
// memory has no reset and no clearing pass; a word reads back garbage
// until it has been written. Only one access touches the memory per cycle,
// so no forwarding is needed.
`default_nettype none

module fixed_latency_burst_memory #(
    parameter int WORD_BYTES  = flbm_pkg::DEF_WORD_BYTES,
    parameter int LATENCY     = flbm_pkg::DEF_LATENCY,
    parameter int BURST_WORDS = flbm_pkg::DEF_BURST_WORDS,
    parameter int MEM_BYTES   = flbm_pkg::DEF_MEM_BYTES,
    parameter int TAG_BITS    = flbm_pkg::DEF_TAG_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // addr, wdata, byte_enable, tag
    input  wire logic [95:0] s_tdata,
    // op, req_type
    input  wire logic [3:0]  s_tuser,
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // resp_tag, resp_data, request_busy, status, zero pad
    output logic      [79:0] m_tdata,
    // resp_valid, resp_type
    output logic      [2:0]  m_tuser
);

    import flbm_pkg::*;

    localparam int DATA_W     = 8 * WORD_BYTES;
    localparam int TAG_W      = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int MEM_WORDS  = MEM_BYTES / WORD_BYTES;
    localparam int IDX_W      = $clog2(MEM_WORDS);
    localparam int SLOT_W     = (LATENCY > 1) ? $clog2(LATENCY) : 1;
    localparam int BURST_N    = (BURST_WORDS > LATENCY) ? LATENCY : BURST_WORDS;
    localparam int RANGE_W    = 26;
    localparam int DIV_SHIFT  = 19;
    localparam int PROD_W     = ADDR_W + DIV_SHIFT + 1;

    localparam logic [DIV_SHIFT:0]  DIV_MUL =
        (DIV_SHIFT + 1)'((2**DIV_SHIFT + WORD_BYTES - 1) / WORD_BYTES);
    localparam logic [RANGE_W-1:0]  WORD_SPAN  = RANGE_W'(WORD_BYTES);
    localparam logic [RANGE_W-1:0]  BURST_SPAN = RANGE_W'(BURST_WORDS * WORD_BYTES);
    localparam logic [RANGE_W-1:0]  MEM_LIMIT  = RANGE_W'(MEM_BYTES);
    localparam logic [SLOT_W-1:0]   FIRST_SLOT = SLOT_W'(LATENCY - BURST_N);
    localparam logic [SLOT_W-1:0]   LAST_SLOT  = SLOT_W'(LATENCY - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // accepted request
    op_t                   in_op_reg;
    req_t                  in_type_reg;
    logic [ADDR_W-1:0]     in_addr_reg;
    logic [DATA_W-1:0]     in_wdata_reg;
    logic [WORD_BYTES-1:0] in_be_reg;
    logic [TAG_W-1:0]      in_tag_reg;

    // pending request register
    logic                  pend_valid_reg, pend_valid_next;
    req_t                  pend_type_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [TAG_W-1:0]      pend_tag_reg;

    status_t               status_reg, status_next;
    logic [SLOT_W-1:0]     fill_slot_reg;
    req_t                  fill_type_reg;
    logic [IDX_W-1:0]      rd_idx_reg;

    logic                  out_valid_reg;
    logic [79:0]           out_data_reg;
    logic [2:0]            out_user_reg;

    logic                  in_fire;
    logic                  req_take;
    logic                  fill_start;
    logic                  fill_issue;
    logic                  out_load;
    req_t                  fill_type_start;
    logic [SLOT_W-1:0]     fill_slot_start;

    logic [PROD_W-1:0]     div_prod;
    logic [ADDR_W-1:0]     quot;
    logic [IDX_W+ADDR_W-1:0] quot_ext;
    logic [IDX_W-1:0]      word_idx;
    logic                  aligned;
    logic [RANGE_W-1:0]    req_end;
    logic                  out_of_range;

    line_ctrl_t            line_ctrl;
    logic                  head_valid;
    req_t                  head_type;
    logic [TAG_W-1:0]      head_tag;
    logic [DATA_W-1:0]     head_data;
    logic                  burst_room;

    logic [WORD_BYTES-1:0] mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_W-1:0]     mem_rdata;

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    // word index by reciprocal multiply; the fraction bits give the alignment
    assign div_prod = PROD_W'(in_addr_reg) * PROD_W'(DIV_MUL);
    assign quot     = div_prod[DIV_SHIFT +: ADDR_W];
    assign aligned  = (div_prod[DIV_SHIFT-1:0] < DIV_MUL[DIV_SHIFT-1:0]) ||
                      DIV_MUL[DIV_SHIFT];
    assign quot_ext = {{IDX_W{1'b0}}, quot};
    assign word_idx = quot_ext[IDX_W-1:0];

    // bounds cover the whole burst
    assign req_end      = RANGE_W'(in_addr_reg) +
                          ((in_type_reg == REQ_BURST) ? BURST_SPAN : WORD_SPAN);
    assign out_of_range = req_end > MEM_LIMIT;

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        pend_valid_next = pend_valid_reg;
        line_ctrl       = '0;
        req_take        = 1'b0;
        fill_start      = 1'b0;
        fill_issue      = 1'b0;
        fill_type_start = REQ_SINGLE;
        fill_slot_start = LAST_SLOT;
        out_load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_FIN;
                status_next = ST_OK;
                case (in_op_reg)
                    OP_REQUEST:
                    begin
                        if (pend_valid_reg)
                        begin
                            status_next = ST_BUSY;
                        end
                        else if (in_type_reg == REQ_NONE)
                        begin
                            status_next = ST_OK;
                        end
                        else if (!aligned)
                        begin
                            status_next = ST_UNALIGNED;
                        end
                        else if (out_of_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            req_take        = 1'b1;
                            pend_valid_next = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        line_ctrl.shift = 1'b1;
                        if (pend_valid_reg)
                        begin
                            if (pend_type_reg == REQ_STORE)
                            begin
                                pend_valid_next = 1'b0;
                            end
                            else if (pend_type_reg == REQ_SINGLE)
                            begin
                                pend_valid_next = 1'b0;
                                fill_start      = 1'b1;
                                fill_type_start = REQ_SINGLE;
                                fill_slot_start = LAST_SLOT;
                                state_next      = S_FILL;
                            end
                            else if (pend_type_reg == REQ_BURST && burst_room)
                            begin
                                pend_valid_next = 1'b0;
                                fill_start      = 1'b1;
                                fill_type_start = REQ_BURST;
                                fill_slot_start = FIRST_SLOT;
                                state_next      = S_FILL;
                            end
                        end
                    end
                    OP_DEQUEUE:
                    begin
                        if (head_valid)
                        begin
                            line_ctrl.dequeue = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_FILL:
            begin
                // word read last cycle lands in its slot, the next read goes out unless this is the last slot
                line_ctrl.put = 1'b1;
                if (fill_slot_reg == LAST_SLOT)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    fill_issue = 1'b1;
                end
            end
            S_FIN:
            begin
                out_load   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_we    = (req_take && in_type_reg == REQ_STORE) ? in_be_reg : '0;
    assign mem_re    = fill_start || fill_issue;
    assign mem_raddr = fill_start ? pend_idx_reg : rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            status_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            status_reg     <= status_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= s_tuser[1:0];
            in_type_reg  <= s_tuser[3:2];
            in_addr_reg  <= s_tdata[15:0];
            in_wdata_reg <= s_tdata[16 +: DATA_W];
            in_be_reg    <= s_tdata[80 +: WORD_BYTES];
            in_tag_reg   <= s_tdata[88 +: TAG_W];
        end
        if (req_take)
        begin
            pend_type_reg <= in_type_reg;
            pend_idx_reg  <= word_idx;
            pend_tag_reg  <= in_tag_reg;
        end
        if (fill_start)
        begin
            fill_slot_reg <= fill_slot_start;
            fill_type_reg <= fill_type_start;
            rd_idx_reg    <= pend_idx_reg + IDX_W'(1);
        end
        else if (line_ctrl.put)
        begin
            fill_slot_reg <= fill_slot_reg + SLOT_W'(1);
            if (fill_issue)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
        if (out_load)
        begin
            out_data_reg[7:0]   <= head_valid ? 8'(head_tag) : 8'd0;
            out_data_reg[71:8]  <= head_valid ? 64'(head_data) : 64'd0;
            out_data_reg[72]    <= pend_valid_reg;
            out_data_reg[75:73] <= status_reg;
            out_data_reg[79:76] <= 4'd0;
            out_user_reg[0]     <= head_valid;
            out_user_reg[2:1]   <= head_valid ? head_type : REQ_BURST;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    flbm_mem #(
        .WORD_BYTES (WORD_BYTES),
        .DEPTH      (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (word_idx),
        .wdata (in_wdata_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    flbm_line #(
        .LATENCY     (LATENCY),
        .BURST_WORDS (BURST_WORDS),
        .TAG_W       (TAG_W),
        .DATA_W      (DATA_W)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (line_ctrl),
        .put_slot   (fill_slot_reg),
        .put_type   (fill_type_reg),
        .put_tag    (pend_tag_reg),
        .put_data   (mem_rdata),
        .head_valid (head_valid),
        .head_type  (head_type),
        .head_tag   (head_tag),
        .head_data  (head_data),
        .burst_room (burst_room)
    );

endmodule

`default_nettype wire
